/* rtl/sphc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor packet health check package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package sphc_pkg;

	// Command carried in tuser with each request.
	typedef enum logic [1:0] {
		CMD_EVAL  = 2'd0,
		CMD_ATT   = 2'd1,
		CMD_SUN   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_STEP   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_LIMIT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAG_MIN    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAG_MAX    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SUN_MIN    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_SUN_MAX    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_SUN_LEVEL  = 3'd6;
	localparam int CFG_DATA_W = 32;

	// Configuration reset values.
	localparam logic [31:0] MAX_STEP_RST   = 32'd100000;
	localparam logic [14:0] GYRO_LIMIT_RST = 15'd16000;
	localparam logic [16:0] MAG_MIN_RST    = 17'd15000;
	localparam logic [16:0] MAG_MAX_RST    = 17'd70000;
	localparam logic [11:0] SUN_MIN_RST    = 12'd0;
	localparam logic [11:0] SUN_MAX_RST    = 12'd4095;
	localparam logic [11:0] SUN_LEVEL_RST  = 12'd2048;

	// Squared magnetometer thresholds.
	localparam int MAG_SQ_W = 34;
	localparam logic [MAG_SQ_W-1:0] MAG_MIN_SQ_RST =
		MAG_SQ_W'(MAG_MIN_RST) * MAG_SQ_W'(MAG_MIN_RST);
	localparam logic [MAG_SQ_W-1:0] MAG_MAX_SQ_RST =
		MAG_SQ_W'(MAG_MAX_RST) * MAG_SQ_W'(MAG_MAX_RST);

	// One axis squared, and the sum of three.
	localparam int AXIS_SQ_W = 35;
	localparam int NORM_SQ_W = 36;

	// Invalid-streak limits and counter widths.
	localparam int ATT_STALE_COUNT = 5;
	localparam int SUN_STALE_COUNT = 5;
	localparam int ATT_STREAK_W = $clog2(ATT_STALE_COUNT + 1);
	localparam int SUN_STREAK_W = $clog2(SUN_STALE_COUNT + 1);

	// Report bit positions.
	localparam int REPORT_W  = 8;
	localparam int BIT_BACK  = 0;
	localparam int BIT_SKIP  = 1;
	localparam int BIT_GYRO  = 2;
	localparam int BIT_MAG   = 3;
	localparam int BIT_SUNR  = 4;
	localparam int BIT_INCOH = 5;
	localparam int BIT_ATT   = 6;
	localparam int BIT_SUN   = 7;

	localparam int SUN_FACE_W = 12;
	localparam int IN_DATA_W  = 208;

	// One request as captured from the input port.
	typedef struct packed {
		cmd_t               cmd;
		logic               valid_flag;
		logic [31:0]        timestamp;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [17:0] mag_x;
		logic signed [17:0] mag_y;
		logic signed [17:0] mag_z;
		logic [35:0]        sun_plus;
		logic [35:0]        sun_minus;
	} item_t;

	// Checks done ahead of the report stage.
	typedef struct packed {
		cmd_t                 cmd;
		logic                 valid_flag;
		logic [31:0]          timestamp;
		logic                 gyro_bad;
		logic                 sun_bad;
		logic                 sun_incoh;
		logic [AXIS_SQ_W-1:0] sq_x;
		logic [AXIS_SQ_W-1:0] sq_y;
		logic [AXIS_SQ_W-1:0] sq_z;
	} front_t;

endpackage
`default_nettype wire

/* rtl/sphc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor packet health check front stage
// Gyro limits, sun-sensor checks and the three magnetometer squares,
// registered for the report stage.
// ----------------------------------------------------------------------------
module sphc_front (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire sphc_pkg::item_t   item,
	input  wire logic [14:0]       gyro_limit,
	input  wire logic [11:0]       sun_min,
	input  wire logic [11:0]       sun_max,
	input  wire logic [11:0]       sun_level,
	output sphc_pkg::front_t       front_s2
);
	import sphc_pkg::*;

	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic [2:0]         gyro_axis_bad;
	logic [2:0]         face_bad;
	logic [2:0]         pair_incoh;
	logic signed [35:0] prod_x;
	logic signed [35:0] prod_y;
	logic signed [35:0] prod_z;
	front_t             front_d;

	// Per-axis gyro limit, strict on both sides.
	assign lim_pos = $signed({2'b00, gyro_limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		gyro_axis_bad[0] = (17'(item.gyro_x) > lim_pos) || (17'(item.gyro_x) < lim_neg);
		gyro_axis_bad[1] = (17'(item.gyro_y) > lim_pos) || (17'(item.gyro_y) < lim_neg);
		gyro_axis_bad[2] = (17'(item.gyro_z) > lim_pos) || (17'(item.gyro_z) < lim_neg);
	end

	// Sun faces: range check on all six, opposite pairs against the level.
	always_comb begin
		logic [11:0] p;
		logic [11:0] n;
		for (int a = 0; a < 3; a++) begin
			p = item.sun_plus[a*SUN_FACE_W +: SUN_FACE_W];
			n = item.sun_minus[a*SUN_FACE_W +: SUN_FACE_W];
			face_bad[a] = (p < sun_min) || (p > sun_max) ||
				(n < sun_min) || (n > sun_max);
			pair_incoh[a] = (p > sun_level) && (n > sun_level);
		end
	end

	// Magnetometer squares, one multiplier per axis.
	assign prod_x = item.mag_x * item.mag_x;
	assign prod_y = item.mag_y * item.mag_y;
	assign prod_z = item.mag_z * item.mag_z;

	always_comb begin
		front_d.cmd        = item.cmd;
		front_d.valid_flag = item.valid_flag;
		front_d.timestamp  = item.timestamp;
		front_d.gyro_bad   = |gyro_axis_bad;
		front_d.sun_bad    = |face_bad;
		front_d.sun_incoh  = |pair_incoh;
		front_d.sq_x       = prod_x[AXIS_SQ_W-1:0];
		front_d.sq_y       = prod_y[AXIS_SQ_W-1:0];
		front_d.sq_z       = prod_z[AXIS_SQ_W-1:0];
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (en) begin
			front_s2 <= front_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/sensor_packet_health_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor packet health check
// Checks attitude-sensor packets and tracks attitude and sun-sensor
// validity streaks; every request returns the current 8-bit report.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tuser command, s_tdata packet
//  m_*     | out       | m_tvalid/m_tready  | m_tdata report flags
//  cfg_*   | in        | cfg_we             | cfg_addr index, cfg_wdata value
//
// Three register stages: input, front checks with the magnetometer squares,
// and the report register, which is also the output register. One request
// is taken every cycle when the output is drained.
// Report state updates in request order at the report stage, so requests
// follow back to back. Each stage moves when the next one is empty or moving,
// so a waiting result does not stop the input until the pipe is full.
// Reset clears all checker state and restores the register defaults.
// ----------------------------------------------------------------------------
module sensor_packet_health_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [0] valid_flag, [32:1] timestamp, [48:33] gyro_x, [64:49] gyro_y,
	// [80:65] gyro_z, [98:81] mag_x, [116:99] mag_y, [134:117] mag_z,
	// [170:135] sun_plus, [206:171] sun_minus, [207] zero
	input  wire logic [sphc_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  wire logic [1:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [0] time_backwards, [1] time_skip, [2] gyro_out_of_range,
	// [3] mag_out_of_range, [4] sun_out_of_range, [5] sun_incoherent,
	// [6] attitude_stale, [7] sun_stale
	output logic [sphc_pkg::REPORT_W-1:0]      m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [sphc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [sphc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sphc_pkg::*;

	localparam logic [ATT_STREAK_W-1:0] ATT_LIMIT = ATT_STREAK_W'(ATT_STALE_COUNT);
	localparam logic [SUN_STREAK_W-1:0] SUN_LIMIT = SUN_STREAK_W'(SUN_STALE_COUNT);

	// Configuration registers.
	logic [31:0]         max_step_q;
	logic [14:0]         gyro_limit_q;
	logic [16:0]         mag_min_q;
	logic [16:0]         mag_max_q;
	logic [11:0]         sun_min_q;
	logic [11:0]         sun_max_q;
	logic [11:0]         sun_level_q;
	logic [MAG_SQ_W-1:0] mag_min_sq_q;
	logic [MAG_SQ_W-1:0] mag_max_sq_q;

	// Pipeline.
	logic     v_s1;
	logic     v_s2;
	logic     out_v_q;
	item_t    item_d;
	item_t    item_s1;
	front_t   front_s2;
	logic     adv2;
	logic     adv3;
	logic     load3;

	// Checker state.
	logic [31:0]             last_time_q;
	logic                    time_seen_q;
	logic [ATT_STREAK_W-1:0] att_streak_q;
	logic [SUN_STREAK_W-1:0] sun_streak_q;
	logic [REPORT_W-1:0]     report_q;

	// Report stage logic.
	logic [NORM_SQ_W-1:0]    norm_sq;
	logic [31:0]             step;
	logic                    back;
	logic                    skip;
	logic                    mag_bad;
	logic [ATT_STREAK_W-1:0] att_next;
	logic [SUN_STREAK_W-1:0] sun_next;
	logic [REPORT_W-1:0]     eval_report;

	// Configuration writes; out-of-list indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q   <= MAX_STEP_RST;
			gyro_limit_q <= GYRO_LIMIT_RST;
			mag_min_q    <= MAG_MIN_RST;
			mag_max_q    <= MAG_MAX_RST;
			sun_min_q    <= SUN_MIN_RST;
			sun_max_q    <= SUN_MAX_RST;
			sun_level_q  <= SUN_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAX_STEP:   max_step_q   <= cfg_wdata;
				CFG_GYRO_LIMIT: gyro_limit_q <= cfg_wdata[14:0];
				CFG_MAG_MIN:    mag_min_q    <= cfg_wdata[16:0];
				CFG_MAG_MAX:    mag_max_q    <= cfg_wdata[16:0];
				CFG_SUN_MIN:    sun_min_q    <= cfg_wdata[11:0];
				CFG_SUN_MAX:    sun_max_q    <= cfg_wdata[11:0];
				CFG_SUN_LEVEL:  sun_level_q  <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// Squared magnetometer thresholds follow their registers in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_min_sq_q <= MAG_MIN_SQ_RST;
			mag_max_sq_q <= MAG_MAX_SQ_RST;
		end else begin
			mag_min_sq_q <= MAG_SQ_W'(mag_min_q) * MAG_SQ_W'(mag_min_q);
			mag_max_sq_q <= MAG_SQ_W'(mag_max_q) * MAG_SQ_W'(mag_max_q);
		end
	end

	// Stage handshakes: a stage moves when the next is empty or moving.
	assign adv3     = !out_v_q || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign s_tready = !v_s1 || adv2;
	assign load3    = v_s2 && adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Unpack the request.
	always_comb begin
		item_d.cmd        = cmd_t'(s_tuser);
		item_d.valid_flag = s_tdata[0];
		item_d.timestamp  = s_tdata[32:1];
		item_d.gyro_x     = s_tdata[48:33];
		item_d.gyro_y     = s_tdata[64:49];
		item_d.gyro_z     = s_tdata[80:65];
		item_d.mag_x      = s_tdata[98:81];
		item_d.mag_y      = s_tdata[116:99];
		item_d.mag_z      = s_tdata[134:117];
		item_d.sun_plus   = s_tdata[170:135];
		item_d.sun_minus  = s_tdata[206:171];
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (s_tready) begin
			item_s1 <= item_d;
		end
	end

	sphc_front u_front (
		.clk        (clk),
		.en         (adv2),
		.item       (item_s1),
		.gyro_limit (gyro_limit_q),
		.sun_min    (sun_min_q),
		.sun_max    (sun_max_q),
		.sun_level  (sun_level_q),
		.front_s2   (front_s2)
	);

	// Timestamp step and field norm.
	assign step    = front_s2.timestamp - last_time_q;
	assign back    = time_seen_q && (front_s2.timestamp < last_time_q);
	assign skip    = time_seen_q && !(front_s2.timestamp < last_time_q) &&
		(step > max_step_q);
	assign norm_sq = NORM_SQ_W'(front_s2.sq_x) + NORM_SQ_W'(front_s2.sq_y) +
		NORM_SQ_W'(front_s2.sq_z);
	assign mag_bad = (norm_sq < NORM_SQ_W'(mag_min_sq_q)) ||
		(norm_sq > NORM_SQ_W'(mag_max_sq_q));

	// Fresh report for an evaluate request; both stale bits are clear.
	always_comb begin
		eval_report            = '0;
		eval_report[BIT_BACK]  = back;
		eval_report[BIT_SKIP]  = skip;
		eval_report[BIT_GYRO]  = front_s2.gyro_bad;
		eval_report[BIT_MAG]   = mag_bad;
		eval_report[BIT_SUNR]  = front_s2.sun_bad;
		eval_report[BIT_INCOH] = front_s2.sun_incoh;
	end

	// Saturating invalid streaks.
	always_comb begin
		if (front_s2.valid_flag) begin
			att_next = '0;
			sun_next = '0;
		end else begin
			att_next = (att_streak_q < ATT_LIMIT) ? att_streak_q + 1'b1 : att_streak_q;
			sun_next = (sun_streak_q < SUN_LIMIT) ? sun_streak_q + 1'b1 : sun_streak_q;
		end
	end

	// Report stage: state updates in request order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q  <= '0;
			time_seen_q  <= 1'b0;
			att_streak_q <= '0;
			sun_streak_q <= '0;
			report_q     <= '0;
		end else if (load3) begin
			unique case (front_s2.cmd)
				CMD_EVAL: begin
					last_time_q <= front_s2.timestamp;
					time_seen_q <= 1'b1;
					report_q    <= eval_report;
				end
				CMD_ATT: begin
					att_streak_q       <= att_next;
					report_q[BIT_ATT]  <= (att_next >= ATT_LIMIT);
				end
				CMD_SUN: begin
					sun_streak_q       <= sun_next;
					report_q[BIT_SUN]  <= (sun_next >= SUN_LIMIT);
				end
				CMD_CLEAR: begin
					last_time_q  <= '0;
					time_seen_q  <= 1'b0;
					att_streak_q <= '0;
					sun_streak_q <= '0;
					report_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = report_q;

	// A clear request leaves an all-zero report.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load3 && front_s2.cmd == CMD_CLEAR) |=> (m_tdata == '0))
		else $error("clear request did not zero the report");

	// An evaluate request drops both stale bits.
	a_eval_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(load3 && front_s2.cmd == CMD_EVAL) |=> (!m_tdata[BIT_ATT] && !m_tdata[BIT_SUN]))
		else $error("evaluate left a stale bit set");

	// Streak counters saturate at their limits.
	a_streak_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(att_streak_q <= ATT_LIMIT) && (sun_streak_q <= SUN_LIMIT))
		else $error("streak counter passed its limit");

	// The attitude stale bit follows its counter after an attitude request.
	a_att_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(load3 && front_s2.cmd == CMD_ATT) |=>
		(m_tdata[BIT_ATT] == (att_streak_q >= ATT_LIMIT)))
		else $error("attitude stale bit disagrees with its counter");

	// The output register changes only when a result is loaded.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load3 |=> $stable(report_q))
		else $error("report changed without a request");

endmodule
`default_nettype wire

/* verif/sensor_packet_health_check_tb.sv */
// ----------------------------------------------------------------------------
// Sensor packet health check testbench
// Streams evaluate, validity and clear requests into the block under several
// limit settings, with random gaps on both sides, and checks every returned
// report flag against an in-bench model of the checker state.
// ----------------------------------------------------------------------------
module sensor_packet_health_check_tb;
	import sphc_pkg::*;

	localparam int ITEMS_PER_PHASE = 150;
	localparam int PHASES          = 8;
	localparam int IDLE_LIMIT      = 400;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]            s_tuser   = CMD_EVAL;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [REPORT_W-1:0]   m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_MAX_STEP;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Limits as currently programmed into the block.
	logic [31:0] lim_max_step  = MAX_STEP_RST;
	logic [14:0] lim_gyro      = GYRO_LIMIT_RST;
	logic [16:0] lim_mag_min   = MAG_MIN_RST;
	logic [16:0] lim_mag_max   = MAG_MAX_RST;
	logic [11:0] lim_sun_min   = SUN_MIN_RST;
	logic [11:0] lim_sun_max   = SUN_MAX_RST;
	logic [11:0] lim_sun_level = SUN_LEVEL_RST;

	// Checker state as the block should hold it.
	logic [31:0]         prev_stamp      = '0;
	logic                stamp_seen      = 1'b0;
	int                  att_invalid_run = 0;
	int                  sun_invalid_run = 0;
	logic [REPORT_W-1:0] health_flags    = '0;

	item_t               pending_reqs [$];
	logic [REPORT_W-1:0] expected_reports [$];
	item_t               in_flight;
	logic [31:0]         gen_time = '0;
	int                  error_count = 0;
	int                  src_gap = 0;
	int                  sink_gap = 0;
	logic                src_calm = 1'b0;
	logic                sink_calm = 1'b0;
	int                  idle_cycles = 0;

	sensor_packet_health_check u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Applies one accepted request to the checker state and returns the report.
	function automatic logic [REPORT_W-1:0] apply_request(input item_t r);
		longint dt;
		longint norm_sq;
		longint mv [3];
		int gv [3];
		int lim;
		int a;
		logic [11:0] p;
		logic [11:0] n;
		case (r.cmd)
			CMD_EVAL: begin
				health_flags = '0;
				if (stamp_seen) begin
					dt = longint'({32'd0, r.timestamp}) - longint'({32'd0, prev_stamp});
					if (dt < 0)
						health_flags[BIT_BACK] = 1'b1;
					if (dt > longint'({32'd0, lim_max_step}))
						health_flags[BIT_SKIP] = 1'b1;
				end
				prev_stamp = r.timestamp;
				stamp_seen = 1'b1;

				gv[0] = $signed(r.gyro_x);
				gv[1] = $signed(r.gyro_y);
				gv[2] = $signed(r.gyro_z);
				lim = lim_gyro;
				for (a = 0; a < 3; a++)
					if (gv[a] > lim || gv[a] < -lim)
						health_flags[BIT_GYRO] = 1'b1;

				mv[0] = $signed(r.mag_x);
				mv[1] = $signed(r.mag_y);
				mv[2] = $signed(r.mag_z);
				norm_sq = mv[0] * mv[0] + mv[1] * mv[1] + mv[2] * mv[2];
				if (norm_sq < longint'(lim_mag_min) * longint'(lim_mag_min) ||
						norm_sq > longint'(lim_mag_max) * longint'(lim_mag_max))
					health_flags[BIT_MAG] = 1'b1;

				for (a = 0; a < 3; a++) begin
					p = r.sun_plus[SUN_FACE_W*a +: SUN_FACE_W];
					n = r.sun_minus[SUN_FACE_W*a +: SUN_FACE_W];
					if (p < lim_sun_min || p > lim_sun_max || n < lim_sun_min || n > lim_sun_max)
						health_flags[BIT_SUNR] = 1'b1;
					if (p > lim_sun_level && n > lim_sun_level)
						health_flags[BIT_INCOH] = 1'b1;
				end
			end
			CMD_ATT: begin
				if (r.valid_flag)
					att_invalid_run = 0;
				else if (att_invalid_run < ATT_STALE_COUNT)
					att_invalid_run++;
				health_flags[BIT_ATT] = (att_invalid_run >= ATT_STALE_COUNT);
			end
			CMD_SUN: begin
				if (r.valid_flag)
					sun_invalid_run = 0;
				else if (sun_invalid_run < SUN_STALE_COUNT)
					sun_invalid_run++;
				health_flags[BIT_SUN] = (sun_invalid_run >= SUN_STALE_COUNT);
			end
			default: begin
				prev_stamp = '0;
				stamp_seen = 1'b0;
				att_invalid_run = 0;
				sun_invalid_run = 0;
				health_flags = '0;
			end
		endcase
		return health_flags;
	endfunction

	// Idle cycles before the next item on either side; none in calm stretches.
	function automatic int draw_gap(input logic calm);
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// A packet that passes every check under the reset limits.
	function automatic item_t clean_packet(input logic [31:0] stamp);
		item_t r;
		r = '0;
		r.cmd = CMD_EVAL;
		r.timestamp = stamp;
		r.mag_x = 18'sd50000;
		r.sun_plus = {3{12'd1000}};
		r.sun_minus = {3{12'd1000}};
		return r;
	endfunction

	// Random request with its fields aimed mostly at the edges of the limits.
	function automatic item_t random_request();
		item_t r;
		int a;
		int v;
		int rim;
		int pick;
		logic signed [15:0] gy [3];
		logic signed [17:0] mg [3];
		logic [11:0] fc [6];
		pick = $urandom_range(0, 59);
		if (pick < 28)
			r.cmd = CMD_EVAL;
		else if (pick < 43)
			r.cmd = CMD_ATT;
		else if (pick < 58)
			r.cmd = CMD_SUN;
		else
			r.cmd = CMD_CLEAR;
		// Mostly invalid so that the streak counters reach their limits.
		r.valid_flag = ($urandom_range(0, 5) == 0);

		// Timestamps step around the allowed maximum, with some going back.
		case ($urandom_range(0, 6))
			0: r.timestamp = gen_time + lim_max_step;
			1: r.timestamp = gen_time + lim_max_step + 32'd1;
			2: r.timestamp = gen_time - 32'd1 - $urandom_range(0, 999);
			3: r.timestamp = gen_time;
			4: r.timestamp = $urandom;
			default: r.timestamp = gen_time + $urandom_range(0, lim_max_step);
		endcase
		if (r.cmd == CMD_EVAL)
			gen_time = r.timestamp;

		for (a = 0; a < 3; a++) begin
			case ($urandom_range(0, 5))
				0: v = lim_gyro;
				1: v = int'(lim_gyro) + 1;
				2: v = -int'(lim_gyro);
				3: v = -int'(lim_gyro) - 1;
				4: v = $urandom_range(0, 1) ? 32767 : -32768;
				default: v = $signed(16'($urandom));
			endcase
			gy[a] = (v > 32767) ? 16'sd32767 : v[15:0];
		end

		for (a = 0; a < 3; a++)
			mg[a] = '0;
		case ($urandom_range(0, 3))
			0: begin
				// One axis on or next to a norm threshold, the others zero.
				rim = $urandom_range(0, 1) ? int'(lim_mag_min) : int'(lim_mag_max);
				rim = rim + int'($urandom_range(0, 2)) - 1;
				if (rim < 0)
					rim = 0;
				if (rim > 131071)
					rim = 131071;
				mg[$urandom_range(0, 2)] = $urandom_range(0, 1) ? -rim : rim;
			end
			1: begin
				for (a = 0; a < 3; a++)
					mg[a] = $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF;
			end
			2: begin
				for (a = 0; a < 3; a++) begin
					v = $urandom_range(0, 80000);
					mg[a] = $urandom_range(0, 1) ? -v : v;
				end
			end
			default: begin
				for (a = 0; a < 3; a++)
					mg[a] = 18'($urandom);
			end
		endcase

		for (a = 0; a < 6; a++) begin
			case ($urandom_range(0, 6))
				0: v = int'(lim_sun_min) - 1;
				1: v = lim_sun_min;
				2: v = lim_sun_max;
				3: v = int'(lim_sun_max) + 1;
				4: v = lim_sun_level;
				5: v = int'(lim_sun_level) + 1;
				default: v = $urandom_range(0, 4095);
			endcase
			fc[a] = (v < 0) ? 12'd0 : (v > 4095) ? 12'hFFF : v[11:0];
		end

		r.gyro_x = gy[0];
		r.gyro_y = gy[1];
		r.gyro_z = gy[2];
		r.mag_x = mg[0];
		r.mag_y = mg[1];
		r.mag_z = mg[2];
		r.sun_plus = {fc[2], fc[1], fc[0]};
		r.sun_minus = {fc[5], fc[4], fc[3]};
		return r;
	endfunction

	// One register write; the model copy follows while nothing is in flight.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		case (addr)
			CFG_MAX_STEP:   lim_max_step = data;
			CFG_GYRO_LIMIT: lim_gyro = data[14:0];
			CFG_MAG_MIN:    lim_mag_min = data[16:0];
			CFG_MAG_MAX:    lim_mag_max = data[16:0];
			CFG_SUN_MIN:    lim_sun_min = data[11:0];
			CFG_SUN_MAX:    lim_sun_max = data[11:0];
			CFG_SUN_LEVEL:  lim_sun_level = data[11:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_limits(input logic [31:0] step, input int gyro, input int mmin,
			input int mmax, input int smin, input int smax, input int level);
		write_reg(CFG_MAX_STEP, step);
		write_reg(CFG_GYRO_LIMIT, gyro);
		write_reg(CFG_MAG_MIN, mmin);
		write_reg(CFG_MAG_MAX, mmax);
		write_reg(CFG_SUN_MIN, smin);
		write_reg(CFG_SUN_MAX, smax);
		write_reg(CFG_SUN_LEVEL, level);
		@(negedge clk);
	endtask

	// Waits until every request is taken and every report has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_reports.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Request driver: predicts each accepted request and loads the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_reports.push_back(apply_request(in_flight));
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_flight = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, in_flight.sun_minus, in_flight.sun_plus,
						in_flight.mag_z, in_flight.mag_y, in_flight.mag_x,
						in_flight.gyro_z, in_flight.gyro_y, in_flight.gyro_x,
						in_flight.timestamp, in_flight.valid_flag};
					s_tuser <= in_flight.cmd;
					src_gap <= draw_gap(src_calm);
					if ($urandom_range(0, 29) == 0)
						src_calm <= !src_calm;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Report monitor: checks each report flag and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		logic [REPORT_W-1:0] want;
		string wrong;
		int f;
		int gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else if (m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: report %b arrived with no request outstanding", $time, m_tdata);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				wrong = "";
				for (f = 0; f < REPORT_W; f++)
					if (m_tdata[f] !== want[f])
						case (f)
							BIT_BACK:  wrong = {wrong, " time_backwards"};
							BIT_SKIP:  wrong = {wrong, " time_skip"};
							BIT_GYRO:  wrong = {wrong, " gyro_out_of_range"};
							BIT_MAG:   wrong = {wrong, " mag_out_of_range"};
							BIT_SUNR:  wrong = {wrong, " sun_out_of_range"};
							BIT_INCOH: wrong = {wrong, " sun_incoherent"};
							BIT_ATT:   wrong = {wrong, " attitude_stale"};
							default:   wrong = {wrong, " sun_stale"};
						endcase
				if (wrong != "") begin
					$display("%0t: report mismatch in%s: expected %b actual %b",
						$time, wrong, want, m_tdata);
					error_count++;
				end
			end
			gap = draw_gap(sink_calm);
			sink_gap <= gap;
			m_tready <= (gap == 0);
			if ($urandom_range(0, 29) == 0)
				sink_calm <= !sink_calm;
		end else if (sink_gap != 0) begin
			sink_gap <= sink_gap - 1;
			m_tready <= (sink_gap == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("sensor_packet_health_check_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed requests at the reset limits, then random phases.
	initial begin
		item_t r;
		int k;
		int ph;
		int mmin;
		int smin;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First packet has no step check; the field is zero.
		r = clean_packet(32'd1000);
		r.mag_x = '0;
		pending_reqs.push_back(r);
		// Exactly the maximum step, gyro exactly on the limit both ways.
		r = clean_packet(32'd101000);
		r.gyro_x = 16'sd16000;
		r.gyro_y = -16'sd16000;
		pending_reqs.push_back(r);
		// One past the maximum step, then one back.
		pending_reqs.push_back(clean_packet(32'd201001));
		pending_reqs.push_back(clean_packet(32'd201000));
		// Timestamp extremes: a huge step forward, then a huge step back.
		pending_reqs.push_back(clean_packet(32'hFFFF_FFFF));
		pending_reqs.push_back(clean_packet(32'd0));
		r = clean_packet(32'd10);
		r.gyro_y = 16'sd16001;
		pending_reqs.push_back(r);
		r = clean_packet(32'd20);
		r.gyro_x = 16'sh8000;
		r.gyro_z = 16'sh7FFF;
		pending_reqs.push_back(r);
		// Field norm on and just under the minimum.
		r = clean_packet(32'd30);
		r.mag_x = 18'sd15000;
		pending_reqs.push_back(r);
		r = clean_packet(32'd40);
		r.mag_x = 18'sd14999;
		pending_reqs.push_back(r);
		// Field norm on and just over the maximum.
		r = clean_packet(32'd50);
		r.mag_x = '0;
		r.mag_z = -18'sd70000;
		pending_reqs.push_back(r);
		r = clean_packet(32'd60);
		r.mag_x = '0;
		r.mag_y = 18'sd70001;
		pending_reqs.push_back(r);
		r = clean_packet(32'd70);
		r.mag_x = 18'h20000;
		r.mag_y = 18'h20000;
		r.mag_z = 18'h20000;
		pending_reqs.push_back(r);
		// Sun faces at full scale, then one pair just above the level.
		r = clean_packet(32'd80);
		r.sun_plus = '1;
		r.sun_minus = '1;
		pending_reqs.push_back(r);
		r = clean_packet(32'd90);
		r.sun_plus[11:0] = 12'd2049;
		r.sun_minus[11:0] = 12'd2049;
		r.sun_plus[23:12] = 12'd2048;
		r.sun_minus[23:12] = 12'd4095;
		pending_reqs.push_back(r);
		// Invalid streaks up to the stale limit on both counters.
		for (k = 0; k < ATT_STALE_COUNT; k++) begin
			r = random_request();
			r.cmd = CMD_ATT;
			r.valid_flag = 1'b0;
			pending_reqs.push_back(r);
			r = random_request();
			r.cmd = CMD_SUN;
			r.valid_flag = 1'b0;
			pending_reqs.push_back(r);
		end
		// Evaluate drops the stale bits but keeps the saturated counters.
		pending_reqs.push_back(clean_packet(32'd100));
		r = random_request();
		r.cmd = CMD_ATT;
		r.valid_flag = 1'b0;
		pending_reqs.push_back(r);
		r.valid_flag = 1'b1;
		pending_reqs.push_back(r);
		r.cmd = CMD_SUN;
		pending_reqs.push_back(r);
		r.cmd = CMD_CLEAR;
		pending_reqs.push_back(r);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain();
				case (ph)
					1: program_limits(32'd0, 0, 0, 0, 0, 0, 0);
					2: program_limits(32'hFFFF_FFFF, 32767, 131071, 131071, 4095, 4095, 4095);
					PHASES - 1: program_limits(MAX_STEP_RST, GYRO_LIMIT_RST, MAG_MIN_RST,
						MAG_MAX_RST, SUN_MIN_RST, SUN_MAX_RST, SUN_LEVEL_RST);
					default: begin
						mmin = $urandom_range(0, 131071);
						smin = $urandom_range(0, 2047);
						program_limits(($urandom_range(0, 3) == 0) ? $urandom :
							$urandom_range(0, 5000), $urandom_range(0, 32767), mmin,
							$urandom_range(mmin, 131071), smin, $urandom_range(smin, 4095),
							$urandom_range(0, 4095));
					end
				endcase
			end
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				pending_reqs.push_back(random_request());
		end

		drain();
		if (error_count == 0)
			$display("sensor_packet_health_check_tb: clean");
		else
			$display("sensor_packet_health_check_tb: errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/sphc_pkg.sv
rtl/sphc_front.sv
rtl/sensor_packet_health_check.sv
verif/sensor_packet_health_check_tb.sv
